>>> rtl/core/ips_pkg.sv
`default_nettype none
package ips_pkg;

    localparam int WORD_W     = 32;
    localparam int LONG_POS   = 31;
    localparam int PARITY_POS = 24;

    // word count of one output group, 1..3
    typedef logic [1:0] grp_cnt_t;

    localparam grp_cnt_t CNT_NONE  = 2'd0;
    localparam grp_cnt_t CNT_ONE   = 2'd1;
    localparam grp_cnt_t CNT_TWO   = 2'd2;
    localparam grp_cnt_t CNT_THREE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        grp_cnt_t          cnt;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [WORD_W-1:0] stamp(input logic [WORD_W-1:0] w,
                                                 input logic par);
        logic [WORD_W-1:0] r;
        r = w;
        r[PARITY_POS] = ~par;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ips_front.sv
`default_nettype none
module ips_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [31:0]               word_in,
    input  wire logic                      region_first,
    input  wire logic                      region_last,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire ips_pkg::q_status_t        q_status,
    output logic                           push,
    output ips_pkg::grp_t                  push_grp
);
    import ips_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_EXT1  = 3'b010,
        PH_EXT2  = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] held_first_reg, held_first_next;
    logic [WORD_W-1:0] held_ext_reg, held_ext_next;
    logic              parity_acc_reg, parity_acc_next;

    logic              accept;
    logic              par_first;
    logic              par_word;
    logic              is_long;
    logic [WORD_W-1:0] o0;
    logic              o0_valid;
    grp_cnt_t          pre_cnt;
    grp_t              grp;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign is_long  = word_in[LONG_POS];
    assign par_word = ^word_in;

    always_comb
    begin
        logic [WORD_W-1:0] masked;
        masked = word_in;
        masked[PARITY_POS] = 1'b0;
        par_first = ^masked;
    end

    // word produced when the current word is taken as a first word
    assign o0       = is_long ? word_in : stamp(word_in, par_first);
    assign o0_valid = !is_long || region_last;

    always_comb
    begin
        phase_next      = phase_reg;
        held_first_next = held_first_reg;
        held_ext_next   = held_ext_reg;
        parity_acc_next = parity_acc_reg;
        grp.word0       = held_first_reg;
        grp.word1       = held_ext_reg;
        grp.word2       = word_in;
        grp.cnt         = CNT_NONE;
        pre_cnt         = CNT_NONE;

        if (region_first || phase_reg == PH_FIRST ||
            (phase_reg != PH_EXT1 && phase_reg != PH_EXT2))
        begin
            // restart flushes held words unchanged
            if (region_first && phase_reg == PH_EXT1)
            begin
                pre_cnt = CNT_ONE;
            end
            else if (region_first && phase_reg == PH_EXT2)
            begin
                pre_cnt = CNT_TWO;
            end
            unique case (pre_cnt)
                CNT_NONE:  grp.word0 = o0;
                CNT_ONE:   grp.word1 = o0;
                default:   grp.word2 = o0;
            endcase
            grp.cnt = grp_cnt_t'(pre_cnt + grp_cnt_t'(o0_valid));
            if (o0_valid)
            begin
                phase_next = PH_FIRST;
            end
            else
            begin
                held_first_next = word_in;
                parity_acc_next = par_first;
                phase_next      = PH_EXT1;
            end
        end
        else if (phase_reg == PH_EXT1)
        begin
            held_ext_next   = word_in;
            parity_acc_next = parity_acc_reg ^ par_word;
            grp.word1       = word_in;
            if (region_last)
            begin
                grp.cnt    = CNT_TWO;
                phase_next = PH_FIRST;
            end
            else
            begin
                phase_next = PH_EXT2;
            end
        end
        else
        begin
            grp.word0  = stamp(held_first_reg, parity_acc_reg ^ par_word);
            grp.cnt    = CNT_THREE;
            phase_next = PH_FIRST;
        end
    end

    assign push     = accept && (grp.cnt != CNT_NONE);
    assign push_grp = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            held_first_reg <= '0;
            held_ext_reg   <= '0;
            parity_acc_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_first_reg <= held_first_next;
            held_ext_reg   <= held_ext_next;
            parity_acc_reg <= parity_acc_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ips_queue.sv
`default_nettype none
module ips_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ips_pkg::grp_t      push_grp,
    input  wire logic               pop,
    output ips_pkg::grp_t           head,
    output ips_pkg::q_status_t      status
);
    import ips_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    grp_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ips_back.sv
`default_nettype none
module ips_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ips_pkg::grp_t        head,
    input  wire ips_pkg::q_status_t   q_status,
    output logic                      pop,
    output logic [31:0]               word_out,
    output logic                      out_last,
    output logic                      out_valid,
    input  wire logic                 out_stall
);
    import ips_pkg::*;

    grp_cnt_t idx_reg, idx_next;
    logic     take;

    assign out_valid = !q_status.empty;
    assign take      = out_valid && !out_stall;
    assign out_last  = (idx_reg == grp_cnt_t'(head.cnt - CNT_ONE));
    assign pop       = take && out_last;

    always_comb
    begin
        unique case (idx_reg)
            CNT_NONE: word_out = head.word0;
            CNT_ONE:  word_out = head.word1;
            default:  word_out = head.word2;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = out_last ? CNT_NONE : grp_cnt_t'(idx_reg + CNT_ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= CNT_NONE;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/instruction_parity_stamper.sv
// Instruction parity stamper. Takes one 32-bit word per cycle unless stalled and
// returns the same words in order, with bit 24 of each instruction's first word set
// to odd parity over the instruction (one word when bit 31 is clear, three words
// when set, bit 24 counted as zero). A three-word first word is held until its
// extensions arrive, so those words leave together. A region that ends or restarts
// inside an instruction releases the held words unchanged. The front end classifies
// and stamps combinationally and writes whole word groups into a QUEUE_DEPTH-entry
// queue; the back end drains one word per cycle unless out_stall is high, so
// sustained throughput is one word per cycle in and out while neither side stalls.
// A single input that flushes a partial instruction ahead of itself yields up to
// three output words. Input stalls only when the queue is full.
`default_nettype none
module instruction_parity_stamper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] word_in,
    input  wire logic        region_first,
    input  wire logic        region_last,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic [31:0]      word_out,
    output logic             out_last,
    output logic             out_valid,
    input  wire logic        out_stall
);
    import ips_pkg::*;

    q_status_t q_status;
    grp_t      push_grp;
    grp_t      head;
    logic      push;
    logic      pop;

    ips_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_in      (word_in),
        .region_first (region_first),
        .region_last  (region_last),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .q_status     (q_status),
        .push         (push),
        .push_grp     (push_grp)
    );

    ips_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    ips_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .word_out  (word_out),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
`default_nettype wire

>>> rtl/core/ips_checker.sv
`default_nettype none
module ips_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [31:0] word_in,
    input wire logic        region_first,
    input wire logic        region_last,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [31:0] word_out,
    input wire logic        out_last,
    input wire logic        out_valid,
    input wire logic        out_stall
);

    // a stalled input transaction stays up with its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(word_in) &&
            $stable(region_first) && $stable(region_last))
        else $error("input transaction changed while stalled");

    // a stalled output transaction stays up
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled output transaction keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(word_out) && $stable(out_last))
        else $error("output payload changed while stalled");

    // words of one group leave back to back
    a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_last |=> out_valid)
        else $error("output group broken before its last word");

    // an empty output side means the queue has room
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with nothing waiting on the output");

endmodule

bind instruction_parity_stamper ips_checker u_ips_checker (.*);
`default_nettype wire
